FILE: rtl/qbp_pkg.sv
// ----------------------------------------------------------------------------
// qbp_pkg
// Shared constants and types for the quantizer and bit packer.
// ----------------------------------------------------------------------------
package qbp_pkg;

  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned MAX_CODE_BITS = 32;
  localparam int unsigned SAMPLE_W      = 32;
  localparam int unsigned CODE_BITS_W   = 6;
  localparam int unsigned PEND_W        = BYTE_BITS - 1;
  localparam int unsigned PEND_CNT_W    = 3;
  // pending bits plus one full code
  localparam int unsigned ACC_W         = PEND_W + MAX_CODE_BITS;
  // five byte slots for the output burst
  localparam int unsigned BURST_W       = 40;
  localparam int unsigned CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET    = 2'd0,
    REG_INV_STEP  = 2'd1,
    REG_CODE_BITS = 2'd2
  } cfg_reg_t;

  localparam logic [CODE_BITS_W-1:0] CODE_BITS_RESET = 6'd8;
  localparam logic [31:0]            INV_STEP_RESET  = 32'd65536;

endpackage

FILE: rtl/quantize_bit_packer.sv
// ----------------------------------------------------------------------------
// quantize_bit_packer
// Linear quantizer with MSB-first bit packing into a byte stream.
// ----------------------------------------------------------------------------
// Each sample has the configured offset subtracted, is scaled by inv_step and
// rounded half up to a code of code_bits bits, clamped to 1..32 (saturating
// at 0 and all ones). Codes are packed MSB first and every full byte goes out
// as one word; a sample with tlast flushes the partial byte zero padded and
// marks the final word. The pipeline is input register, multiply register,
// then a byte burst register that emits one word per cycle while the receiver
// is ready. A new sample enters the burst register as the last word of the
// previous burst is taken, so the output word rate of one byte per cycle,
// less receiver stalls, is what bounds throughput. A sample passes the input,
// multiply and burst registers in that order before its first word goes out.
module quantize_bit_packer (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [qbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic        s_tlast,   // last_sample
  // byte stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast    // last_byte
);

  // configuration registers
  logic signed [31:0] offset;
  logic [31:0]        inv_step;
  logic [qbp_pkg::CODE_BITS_W-1:0] code_bits;

  // input stage
  logic               s1_valid;
  logic signed [31:0] s1_sample;
  logic               s1_last;

  // multiply stage
  logic        s2_valid;
  logic [63:0] s2_prod;
  logic        s2_pos;
  logic        s2_last;

  // packer state
  logic [qbp_pkg::PEND_W-1:0]     pending_bits;
  logic [qbp_pkg::PEND_CNT_W-1:0] pending_count;

  // output burst
  logic [qbp_pkg::BURST_W-1:0] burst;
  logic [2:0]                  burst_left;
  logic                        burst_last;

  // combinational
  logic signed [32:0] diff;
  logic               diff_pos;
  logic [63:0]        prod;
  logic [qbp_pkg::CODE_BITS_W-1:0] nb;
  logic [32:0]        code_round;
  logic [32:0]        code_max;
  logic [31:0]        code;
  logic [qbp_pkg::ACC_W-1:0] acc;
  logic [5:0]         total;
  logic [2:0]         rem_bits;
  logic [2:0]         full_bytes;
  logic [2:0]         burst_count;
  logic [qbp_pkg::BURST_W-1:0] burst_next;
  logic [qbp_pkg::PEND_W-1:0]  pending_bits_next;
  logic        burst_free;
  logic        fire2;
  logic        adv1;
  logic        out_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      inv_step  <= qbp_pkg::INV_STEP_RESET;
      code_bits <= qbp_pkg::CODE_BITS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        qbp_pkg::REG_OFFSET:    offset    <= cfg_data;
        qbp_pkg::REG_INV_STEP:  inv_step  <= cfg_data;
        qbp_pkg::REG_CODE_BITS: code_bits <= cfg_data[qbp_pkg::CODE_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  assign out_fire   = m_tvalid && m_tready;
  assign burst_free = (burst_left == 3'd0) || ((burst_left == 3'd1) && m_tready);
  assign fire2      = s2_valid && burst_free;
  assign adv1       = s1_valid && (!s2_valid || fire2);
  assign s_tready   = !s1_valid || adv1;

  // subtract and multiply
  always_comb begin
    diff     = {s1_sample[31], s1_sample} - {offset[31], offset};
    diff_pos = !diff[32] && (diff != 33'sd0);
    prod     = {32'd0, diff[31:0]} * {32'd0, inv_step};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        s1_valid <= 1'b1;
      end else if (adv1) begin
        s1_valid <= 1'b0;
      end
      if (adv1) begin
        s2_valid <= 1'b1;
      end else if (fire2) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_sample <= s_tdata;
      s1_last   <= s_tlast;
    end
    if (adv1) begin
      s2_prod <= prod;
      s2_pos  <= diff_pos;
      s2_last <= s1_last;
    end
  end

  // round, saturate and pack
  always_comb begin
    if (code_bits == 6'd0) begin
      nb = 6'd1;
    end else if (code_bits > 6'(qbp_pkg::MAX_CODE_BITS)) begin
      nb = 6'(qbp_pkg::MAX_CODE_BITS);
    end else begin
      nb = code_bits;
    end
    code_round = {1'b0, s2_prod[63:32]} + {32'd0, s2_prod[31]};
    code_max   = (33'd1 << nb) - 33'd1;
    if (!s2_pos) begin
      code = '0;
    end else if (code_round > code_max) begin
      code = code_max[31:0];
    end else begin
      code = code_round[31:0];
    end
    acc        = ({32'd0, pending_bits} << nb) | {7'd0, code};
    total      = {3'd0, pending_count} + nb;
    rem_bits   = total[2:0];
    full_bytes = total[5:3];
    burst_count = full_bytes + {2'd0, (s2_last && (rem_bits != 3'd0))};
    // left align so the oldest bit sits at the top
    burst_next = {1'b0, acc} << (6'd40 - total);
    pending_bits_next = acc[qbp_pkg::PEND_W-1:0] & ((7'd1 << rem_bits) - 7'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      burst_left    <= '0;
    end else begin
      if (fire2) begin
        if (s2_last) begin
          pending_bits  <= '0;
          pending_count <= '0;
        end else begin
          pending_bits  <= pending_bits_next;
          pending_count <= rem_bits;
        end
        burst_left <= burst_count;
      end else if (out_fire) begin
        burst_left <= burst_left - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      burst      <= burst_next;
      burst_last <= s2_last;
    end else if (out_fire) begin
      burst <= burst << qbp_pkg::BYTE_BITS;
    end
  end

  assign m_tvalid = (burst_left != 3'd0);
  assign m_tdata  = burst[qbp_pkg::BURST_W-1 -: qbp_pkg::BYTE_BITS];
  assign m_tlast  = burst_last && (burst_left == 3'd1);

endmodule

FILE: tb/quantize_bit_packer_tb.sv
// ----------------------------------------------------------------------------
// quantize_bit_packer_tb
// Self-checking bench for the quantizer and MSB-first byte packer. Samples
// go in on the stream input, and a local model of the quantizer and the
// packer predicts every byte and its tlast flag. Each received word is
// compared with the oldest prediction. Directed cases cover the rounding,
// the saturation and the flush rules. Random buffers run under several
// register settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module quantize_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [qbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // [31:0] sample
  logic                 s_tlast = 1'b0; // last_sample
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // [7:0] out_byte
  logic                 m_tlast;        // last_byte

  // register mirror and packer state of the model
  logic [31:0]          cfg_min = 32'd0;
  logic [31:0]          cfg_inv = qbp_pkg::INV_STEP_RESET;
  logic [qbp_pkg::CODE_BITS_W-1:0] cfg_nbits = qbp_pkg::CODE_BITS_RESET;
  logic [6:0]           held_bits = '0;
  logic [2:0]           held_count = '0;

  byte_word_t  expected_bytes[$];
  byte_word_t  got_word;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  quantize_bit_packer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] quantize_code(logic [31:0] smp, int unsigned nb);
    logic signed [32:0] diff;
    logic [65:0]        prod;
    logic [33:0]        code;
    logic [33:0]        maxc;
    diff = $signed({smp[31], smp}) - $signed({cfg_min[31], cfg_min});
    if (diff <= 0) begin
      code = '0;
    end else begin
      prod = {33'd0, diff[32:0]} * {34'd0, cfg_inv};
      // round half up
      prod = prod + (66'd1 << 31);
      code = prod[65:32];
    end
    maxc = (34'd1 << nb) - 34'd1;
    if (code > maxc) begin
      code = maxc;
    end
    return code[31:0];
  endfunction

  function automatic void pack_sample(logic [31:0] smp, logic lst);
    int unsigned nb;
    int unsigned total;
    int unsigned n;
    logic [38:0] acc;
    logic [38:0] shifted;
    byte_word_t  burst[5];
    nb = cfg_nbits;
    if (nb == 0) begin
      nb = 1;
    end
    if (nb > qbp_pkg::MAX_CODE_BITS) begin
      nb = qbp_pkg::MAX_CODE_BITS;
    end
    acc = ({32'd0, held_bits} << nb) | {7'd0, quantize_code(smp, nb)};
    total = held_count + nb;
    n = 0;
    while (total >= qbp_pkg::BYTE_BITS) begin
      total -= qbp_pkg::BYTE_BITS;
      shifted = acc >> total;
      burst[n].data = shifted[7:0];
      burst[n].last = 1'b0;
      n++;
    end
    if (lst) begin
      if (total > 0) begin
        shifted = acc << (qbp_pkg::BYTE_BITS - total);
        burst[n].data = shifted[7:0];
        burst[n].last = 1'b1;
        n++;
      end else if (n > 0) begin
        burst[n-1].last = 1'b1;
      end
      held_bits = '0;
      held_count = '0;
    end else begin
      shifted = acc & ((39'd1 << total) - 39'd1);
      held_bits = shifted[6:0];
      held_count = total[2:0];
    end
    for (int i = 0; i < n; i++) begin
      expected_bytes.push_back(burst[i]);
    end
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] span;
    if ($urandom_range(9) < 3) begin
      return $urandom;
    end
    // offsets above the minimum so that codes spread over the range
    span = $urandom >> $urandom_range(0, 31);
    return cfg_min + span;
  endfunction

  task automatic send_sample(logic [31:0] smp, logic lst);
    if (!tx_steady && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    pack_sample(smp, lst);
  endtask

  // stop sending and wait until every predicted word has arrived
  task automatic drain_bytes(int unsigned extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(qbp_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      qbp_pkg::REG_OFFSET:    cfg_min = val;
      qbp_pkg::REG_INV_STEP:  cfg_inv = val;
      qbp_pkg::REG_CODE_BITS: cfg_nbits = val[qbp_pkg::CODE_BITS_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_config();
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0000_8000, 1'b0);   // exactly half rounds up
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);   // below minimum
    send_sample(32'h00FF_0000, 1'b0);
    send_sample(32'h012C_0000, 1'b0);   // above range
    send_sample(32'h7FFF_FFFF, 1'b0);
    // full byte on the last sample carries tlast
    send_sample(32'h8000_0000, 1'b1);
    drain_bytes(SETTLE_CYCLES);
  endtask

  task automatic test_code_width_edges();
    write_reg(qbp_pkg::REG_CODE_BITS, 32'd0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b1);
    drain_bytes(SETTLE_CYCLES);
    // seven bits left pending, then a wide code on top of them
    write_reg(qbp_pkg::REG_CODE_BITS, 32'd7);
    send_sample(32'h007F_0000, 1'b0);
    drain_bytes(SETTLE_CYCLES);
    write_reg(qbp_pkg::REG_OFFSET, 32'h8000_0000);
    write_reg(qbp_pkg::REG_INV_STEP, 32'hFFFF_FFFF);
    write_reg(qbp_pkg::REG_CODE_BITS, 32'd63);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b1);
    drain_bytes(SETTLE_CYCLES);
    write_reg(qbp_pkg::REG_CODE_BITS, 32'd33);
    send_sample(32'h0123_4567, 1'b1);
    drain_bytes(SETTLE_CYCLES);
  endtask

  task automatic test_zero_step();
    write_reg(qbp_pkg::REG_INV_STEP, 32'd0);
    write_reg(qbp_pkg::REG_CODE_BITS, 32'd5);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h1234_5678, 1'b1);
    drain_bytes(SETTLE_CYCLES);
  endtask

  task automatic test_high_minimum();
    write_reg(qbp_pkg::REG_OFFSET, 32'h7FFF_FFFF);
    write_reg(qbp_pkg::REG_INV_STEP, 32'h0001_0000);
    write_reg(qbp_pkg::REG_CODE_BITS, 32'd8);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    drain_bytes(SETTLE_CYCLES);
  endtask

  task automatic test_random_buffers();
    int unsigned left;
    int unsigned len;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0: write_reg(qbp_pkg::REG_OFFSET, 32'd0);
        1: write_reg(qbp_pkg::REG_OFFSET, 32'h8000_0000);
        default: write_reg(qbp_pkg::REG_OFFSET, $urandom);
      endcase
      case ($urandom_range(3))
        0: write_reg(qbp_pkg::REG_INV_STEP, $urandom);
        1: write_reg(qbp_pkg::REG_INV_STEP, $urandom_range(1, 32'h0004_0000));
        2: write_reg(qbp_pkg::REG_INV_STEP, 32'hFFFF_FFFF);
        default: write_reg(qbp_pkg::REG_INV_STEP, $urandom_range(0, 255));
      endcase
      if ($urandom_range(4) == 0) begin
        write_reg(qbp_pkg::REG_CODE_BITS, $urandom_range(0, 63));
      end else begin
        write_reg(qbp_pkg::REG_CODE_BITS, $urandom_range(1, 32));
      end
      tx_steady = (ph == 2);
      rx_steady = (ph == 2);
      left = 12;
      while (left > 0) begin
        len = $urandom_range(1, 8);
        if (len > left) begin
          len = left;
        end
        for (int i = 0; i < len; i++) begin
          send_sample(pick_sample(), i == len - 1);
        end
        left -= len;
        if (ph == 3) begin
          drain_bytes(0);
        end
      end
      drain_bytes(SETTLE_CYCLES);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_output_stall();
    write_reg(qbp_pkg::REG_OFFSET, $urandom);
    write_reg(qbp_pkg::REG_INV_STEP, $urandom);
    write_reg(qbp_pkg::REG_CODE_BITS, 32'd32);
    // receiver holds off while samples keep coming, so the input backs up
    rx_hold = 300;
    for (int i = 0; i < 30; i++) begin
      send_sample(pick_sample(), i == 29);
    end
    drain_bytes(SETTLE_CYCLES);
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (rx_steady) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 13);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual data %h last %b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        got_word = expected_bytes.pop_front();
        if (m_tdata !== got_word.data) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, got_word.data, m_tdata);
          errors++;
        end
        if (m_tlast !== got_word.last) begin
          $display("%0t: last_byte mismatch: expected %b, actual %b",
                   $time, got_word.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d words outstanding", $time, expected_bytes.size());
    $display("quantize_bit_packer_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_code_width_edges();
    test_zero_step();
    test_high_minimum();
    test_random_buffers();
    test_output_stall();
    drain_bytes(20);
    if (errors == 0) begin
      $display("quantize_bit_packer_tb OK");
    end else begin
      $display("quantize_bit_packer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/qbp_pkg.sv
rtl/quantize_bit_packer.sv
tb/quantize_bit_packer_tb.sv
